// ===== rtl/tc3e_pkg.sv =====
//------------------------------------------------------------------------------
// tc3e_pkg
// Shared constants for the 3D Euler transform composer.
//------------------------------------------------------------------------------
package tc3e_pkg;

  localparam int TrigFrac = 30;
  localparam int AtanCount = 24;
  localparam int CordicGain = 652032874;

  // atan(2^-i) as a fraction of one turn, 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    begin
      case (idx)
        5'd0:  v = 32'd536870912;
        5'd1:  v = 32'd316933406;
        5'd2:  v = 32'd167458907;
        5'd3:  v = 32'd85004756;
        5'd4:  v = 32'd42667331;
        5'd5:  v = 32'd21354465;
        5'd6:  v = 32'd10679838;
        5'd7:  v = 32'd5340245;
        5'd8:  v = 32'd2670163;
        5'd9:  v = 32'd1335087;
        5'd10: v = 32'd667544;
        5'd11: v = 32'd333772;
        5'd12: v = 32'd166886;
        5'd13: v = 32'd83443;
        5'd14: v = 32'd41722;
        5'd15: v = 32'd20861;
        5'd16: v = 32'd10430;
        5'd17: v = 32'd5215;
        5'd18: v = 32'd2608;
        5'd19: v = 32'd1304;
        5'd20: v = 32'd652;
        5'd21: v = 32'd326;
        5'd22: v = 32'd163;
        5'd23: v = 32'd81;
        default: v = 32'd0;
      endcase
      return v;
    end
  endfunction

endpackage

// ===== rtl/transform_compose_3d_euler_top.sv =====
//------------------------------------------------------------------------------
// transform_compose_3d_euler_top
// Operation: a child item runs its products in turn on one shared multiplier
//   (15 rotation and position products plus 3 scale products, one per cycle);
//   a parent load runs the CORDIC for each axis in turn and gives no result.
// Throughput: one item at a time; ready is low while an item is at work or a
//   result waits.
// Reset: synchronous active-low rst_n restores the identity parent.
//------------------------------------------------------------------------------
module transform_compose_3d_euler_top
  import tc3e_pkg::*;
#(
  parameter int FRAC_BITS    = 16,
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic        [15:0] in_angle_x,
  input  logic        [15:0] in_angle_y,
  input  logic        [15:0] in_angle_z,
  input  logic signed [31:0] in_scale_x,
  input  logic signed [31:0] in_scale_y,
  input  logic signed [31:0] in_scale_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_global_x,
  output logic signed [31:0] out_global_y,
  output logic signed [31:0] out_global_z,
  output logic        [15:0] out_global_angle_x,
  output logic        [15:0] out_global_angle_y,
  output logic        [15:0] out_global_angle_z,
  output logic signed [31:0] out_global_scale_x,
  output logic signed [31:0] out_global_scale_y,
  output logic signed [31:0] out_global_scale_z
);

  localparam int TW = FRAC_BITS + 2;            // trig width, Q1.FRAC
  localparam int SHW = TrigFrac - FRAC_BITS;
  localparam int NS = (CORDIC_STEPS < AtanCount) ? CORDIC_STEPS : AtanCount;
  localparam logic [15:0] AMASK = 16'((32'd1 << ANGLE_BITS) - 32'd1);
  localparam logic signed [TW-1:0] ONE_T = TW'(1) << FRAC_BITS;
  localparam logic signed [31:0] ONE_S = 32'sd1 <<< FRAC_BITS;

  typedef enum logic [2:0] {S_IDLE, S_TRIG_INIT, S_TRIG_STEP, S_TRIG_DONE,
                            S_CHILD, S_OUT} state_t;

  state_t state_r;
  logic [3:0] step_r;       // child product index
  logic [4:0] it_r;         // cordic iteration
  logic [1:0] ax_r;         // cordic axis

  logic signed [31:0] ppos_r [3];
  logic        [15:0] pang_r [3];
  logic signed [31:0] pscl_r [3];
  logic signed [TW-1:0] pcos_r [3];
  logic signed [TW-1:0] psin_r [3];

  logic signed [31:0] cpos_r [3];
  logic        [15:0] cang_r [3];
  logic signed [31:0] cscl_r [3];

  // cordic registers
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic [1:0] quad_r;
  logic zero_r;

  // child datapath
  logic signed [63:0] acc_r;
  logic signed [49:0] sx_r, sy_r, sz_r;  // scaled and sat; feed the rotation
  logic signed [63:0] y1_r, z1_r, x2_r;
  logic signed [31:0] gs_r [3];

  // outputs
  logic signed [31:0] ox_r, oy_r, oz_r;

  function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
    return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // shared multiplier operand select
  logic signed [32:0] ma;
  logic signed [35:0] mb;
  logic signed [68:0] prod_w;
  logic signed [63:0] prod;
  logic acc_clr;
  logic signed [TW-1:0] c0, s0, c1, s1, c2, s2;
  assign c0 = pcos_r[0]; assign s0 = psin_r[0];
  assign c1 = pcos_r[1]; assign s1 = psin_r[1];
  assign c2 = pcos_r[2]; assign s2 = psin_r[2];

  always_comb begin
    ma = '0; mb = '0; acc_clr = 1'b1;
    case (step_r)
      4'd0:  begin ma = 33'(cpos_r[0]); mb = 36'(pscl_r[0]); end
      4'd1:  begin ma = 33'(cpos_r[1]); mb = 36'(pscl_r[1]); end
      4'd2:  begin ma = 33'(cpos_r[2]); mb = 36'(pscl_r[2]); end
      4'd3:  begin ma = 33'(c0); mb = 36'(sy_r); end
      4'd4:  begin ma = -33'(s0); mb = 36'(sz_r); acc_clr = 1'b0; end
      4'd5:  begin ma = 33'(s0); mb = 36'(sy_r); end
      4'd6:  begin ma = 33'(c0); mb = 36'(sz_r); acc_clr = 1'b0; end
      4'd7:  begin ma = 33'(c1); mb = 36'(sx_r); end
      4'd8:  begin ma = 33'(s1); mb = 36'(z1_r); acc_clr = 1'b0; end
      4'd9:  begin ma = 33'(c1); mb = 36'(z1_r); end
      4'd10: begin ma = -33'(s1); mb = 36'(sx_r); acc_clr = 1'b0; end
      4'd11: begin ma = 33'(c2); mb = 36'(x2_r); end
      4'd12: begin ma = -33'(s2); mb = 36'(y1_r); acc_clr = 1'b0; end
      4'd13: begin ma = 33'(s2); mb = 36'(x2_r); end
      4'd14: begin ma = 33'(c2); mb = 36'(y1_r); acc_clr = 1'b0; end
      // scale products reuse the multiplier after the rotation
      default: begin ma = 33'(pscl_r[sk_r]); mb = 36'(cscl_r[sk_r]); end
    endcase
  end
  assign prod_w = ma * mb;
  assign prod = prod_w[63:0];

  logic signed [63:0] sum;
  assign sum = acc_clr ? prod : acc_r + prod;

  logic [1:0] sk_r;

  // cordic step
  logic signed [33:0] dx, dy, az;
  assign dx = cy_r >>> it_r;
  assign dy = cx_r >>> it_r;
  assign az = 34'(atan_turn(it_r));

  logic [15:0] ang_sel;
  logic [31:0] turn;
  assign ang_sel = pang_r[ax_r];
  assign turn = 32'(ang_sel & AMASK) << (32 - ANGLE_BITS);

  logic signed [33:0] cr, sr;
  logic signed [TW-1:0] cc, ss, cq, sq;
  assign cr = (cx_r + (34'sd1 <<< (SHW - 1))) >>> SHW;
  assign sr = (cy_r + (34'sd1 <<< (SHW - 1))) >>> SHW;
  always_comb begin
    if (zero_r) begin
      cc = ONE_T; ss = '0;
    end else begin
      cc = (cr > 34'(ONE_T)) ? ONE_T : (cr < -34'(ONE_T)) ? -ONE_T : TW'(cr);
      ss = (sr > 34'(ONE_T)) ? ONE_T : (sr < -34'(ONE_T)) ? -ONE_T : TW'(sr);
    end
    case (quad_r)
      2'd0: begin cq = cc; sq = ss; end
      2'd1: begin cq = -ss; sq = cc; end
      2'd2: begin cq = -cc; sq = -ss; end
      default: begin cq = ss; sq = -cc; end
    endcase
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= '0; it_r <= '0; ax_r <= '0; sk_r <= '0;
      for (int k = 0; k < 3; k++) begin
        ppos_r[k] <= '0; pang_r[k] <= '0; pscl_r[k] <= ONE_S;
        pcos_r[k] <= ONE_T; psin_r[k] <= '0;
      end
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) begin
          cpos_r[0] <= in_pos_x; cpos_r[1] <= in_pos_y; cpos_r[2] <= in_pos_z;
          cang_r[0] <= in_angle_x & AMASK; cang_r[1] <= in_angle_y & AMASK;
          cang_r[2] <= in_angle_z & AMASK;
          cscl_r[0] <= in_scale_x; cscl_r[1] <= in_scale_y;
          cscl_r[2] <= in_scale_z;
          step_r <= '0; sk_r <= '0;
          if (!in_op) begin
            ppos_r[0] <= in_pos_x; ppos_r[1] <= in_pos_y; ppos_r[2] <= in_pos_z;
            pang_r[0] <= in_angle_x & AMASK; pang_r[1] <= in_angle_y & AMASK;
            pang_r[2] <= in_angle_z & AMASK;
            pscl_r[0] <= in_scale_x; pscl_r[1] <= in_scale_y;
            pscl_r[2] <= in_scale_z;
            ax_r <= '0;
            state_r <= S_TRIG_INIT;
          end else begin
            state_r <= S_CHILD;
          end
        end
        S_TRIG_INIT: begin
          cx_r <= 34'(CordicGain); cy_r <= '0;
          cz_r <= {4'b0, turn[29:0]};
          quad_r <= turn[31:30];
          zero_r <= (turn[29:0] == '0);
          it_r <= '0;
          state_r <= (NS == 0) ? S_TRIG_DONE : S_TRIG_STEP;
        end
        S_TRIG_STEP: begin
          if (!cz_r[33]) begin
            cx_r <= cx_r - dx; cy_r <= cy_r + dy; cz_r <= cz_r - az;
          end else begin
            cx_r <= cx_r + dx; cy_r <= cy_r - dy; cz_r <= cz_r + az;
          end
          it_r <= it_r + 5'd1;
          if (it_r == 5'(NS - 1)) state_r <= S_TRIG_DONE;
        end
        S_TRIG_DONE: begin
          pcos_r[ax_r] <= cq; psin_r[ax_r] <= sq;
          if (ax_r == 2'd2) state_r <= S_IDLE;
          else begin
            ax_r <= ax_r + 2'd1;
            state_r <= S_TRIG_INIT;
          end
        end
        S_CHILD: begin
          acc_r <= sum;
          // hold on the last index while the three scale products run
          if (step_r != 4'd15) step_r <= step_r + 4'd1;
          case (step_r)
            4'd0: sx_r <= 50'(sat(rnd(prod)));
            4'd1: sy_r <= 50'(sat(rnd(prod)));
            4'd2: sz_r <= 50'(sat(rnd(prod)));
            4'd3, 4'd5, 4'd7, 4'd9, 4'd11, 4'd13: begin
            end
            4'd4: y1_r <= rnd(sum);
            4'd6: z1_r <= rnd(sum);
            4'd8: x2_r <= rnd(sum);
            4'd10: begin
              oz_r <= sat(64'(ppos_r[2]) + rnd(sum));
            end
            4'd12: ox_r <= sat(64'(ppos_r[0]) + rnd(sum));
            4'd14: begin
              oy_r <= sat(64'(ppos_r[1]) + rnd(sum));
            end
            default: begin
              gs_r[sk_r] <= sat(rnd(prod));
              sk_r <= sk_r + 2'd1;
              if (sk_r == 2'd2) state_r <= S_OUT;
            end
          endcase
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_global_x = ox_r;
  assign out_global_y = oy_r;
  assign out_global_z = oz_r;
  assign out_global_angle_x = (pang_r[0] + cang_r[0]) & AMASK;
  assign out_global_angle_y = (pang_r[1] + cang_r[1]) & AMASK;
  assign out_global_angle_z = (pang_r[2] + cang_r[2]) & AMASK;
  assign out_global_scale_x = gs_r[0];
  assign out_global_scale_y = gs_r[1];
  assign out_global_scale_z = gs_r[2];

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_global_x))
    else $error("result dropped");
  a_child_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_op |=> !out_valid)
    else $error("parent load gave result");

endmodule

// ===== test/transform_compose_3d_euler_top_tb.sv =====
//------------------------------------------------------------------------------
// transform_compose_3d_euler_top_tb
// Sends parent loads and child items, some directed and some random, over the
// valid/ready channels. Each child item's composed transform is predicted
// here and compared field by field with the result. Both sides idle at
// random, and the receiver also holds off for one long stretch.
//------------------------------------------------------------------------------
module transform_compose_3d_euler_top_tb;
  import tc3e_pkg::*;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CHILD = 1'b1;
  localparam int   UNIT     = 65536;
  localparam int   HOLD_CYCLES = 400;

  localparam longint ATAN_TURNS [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  typedef struct {
    logic              op;
    logic signed [31:0] pos [3];
    logic        [15:0] ang [3];
    logic signed [31:0] scl [3];
  } xform_item_t;

  typedef struct {
    logic signed [31:0] gpos [3];
    logic        [15:0] gang [3];
    logic signed [31:0] gscl [3];
  } composed_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready, in_op;
  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z;
  logic        [15:0] in_angle_x, in_angle_y, in_angle_z;
  logic signed [31:0] in_scale_x, in_scale_y, in_scale_z;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_global_x, out_global_y, out_global_z;
  logic        [15:0] out_global_angle_x, out_global_angle_y, out_global_angle_z;
  logic signed [31:0] out_global_scale_x, out_global_scale_y, out_global_scale_z;

  transform_compose_3d_euler_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parent held by the predictor
  longint par_pos [3];
  logic [15:0] par_ang [3];
  longint par_scl [3];
  longint par_cos [3];
  longint par_sin [3];

  composed_t expected_q [$];
  int errors = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  function automatic longint round_q16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > UNIT) return UNIT;
    if (v < -UNIT) return -UNIT;
    return v;
  endfunction

  task automatic angle_trig(input logic [15:0] a, output longint cosv, output longint sinv);
    logic [31:0] turn;
    longint c, s, x, y, z, dx, dy;
    turn = {a, 16'h0000};
    if (turn[29:0] == 30'd0) begin
      c = UNIT;
      s = 0;
    end else begin
      x = 652032874;
      y = 0;
      z = longint'(turn[29:0]);
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= ATAN_TURNS[i];
        end else begin
          x += dx; y -= dy; z += ATAN_TURNS[i];
        end
      end
      c = clamp_unit((x + 8192) >>> 14);
      s = clamp_unit((y + 8192) >>> 14);
    end
    case (turn[31:30])
      2'd0: begin cosv = c;  sinv = s;  end
      2'd1: begin cosv = -s; sinv = c;  end
      2'd2: begin cosv = -c; sinv = -s; end
      default: begin cosv = s; sinv = -c; end
    endcase
  endtask

  task automatic reset_parent();
    for (int k = 0; k < 3; k++) begin
      par_pos[k] = 0;
      par_ang[k] = '0;
      par_scl[k] = UNIT;
      par_cos[k] = UNIT;
      par_sin[k] = 0;
    end
  endtask

  // Update the parent, or push the composed transform of a child.
  task automatic predict_compose(input xform_item_t it);
    composed_t r;
    longint x, y, z, y1, z1, x2, z2;
    if (it.op == OP_LOAD) begin
      for (int k = 0; k < 3; k++) begin
        par_pos[k] = it.pos[k];
        par_ang[k] = it.ang[k];
        par_scl[k] = it.scl[k];
        angle_trig(it.ang[k], par_cos[k], par_sin[k]);
      end
    end else begin
      x = sat32(round_q16(longint'(it.pos[0]) * par_scl[0]));
      y = sat32(round_q16(longint'(it.pos[1]) * par_scl[1]));
      z = sat32(round_q16(longint'(it.pos[2]) * par_scl[2]));
      y1 = round_q16(par_cos[0] * y - par_sin[0] * z);
      z1 = round_q16(par_sin[0] * y + par_cos[0] * z);
      x2 = round_q16(par_cos[1] * x + par_sin[1] * z1);
      z2 = round_q16(par_cos[1] * z1 - par_sin[1] * x);
      r.gpos[0] = 32'(sat32(par_pos[0] + round_q16(par_cos[2] * x2 - par_sin[2] * y1)));
      r.gpos[1] = 32'(sat32(par_pos[1] + round_q16(par_sin[2] * x2 + par_cos[2] * y1)));
      r.gpos[2] = 32'(sat32(par_pos[2] + z2));
      for (int k = 0; k < 3; k++) begin
        r.gang[k] = par_ang[k] + it.ang[k];
        r.gscl[k] = 32'(sat32(round_q16(par_scl[k] * longint'(it.scl[k]))));
      end
      expected_q.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // Drive one item and hold it until accepted.
  task automatic send_item(input xform_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= it.op;
    in_pos_x   <= it.pos[0];
    in_pos_y   <= it.pos[1];
    in_pos_z   <= it.pos[2];
    in_angle_x <= it.ang[0];
    in_angle_y <= it.ang[1];
    in_angle_z <= it.ang[2];
    in_scale_x <= it.scl[0];
    in_scale_y <= it.scl[1];
    in_scale_z <= it.scl[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_compose(it);
  endtask

  // Mix of small, moderate, full-range and extreme values.
  function automatic logic [31:0] pick_value(input int span);
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return 32'($signed($urandom_range(2 * span)) - span);
    endcase
  endfunction

  function automatic xform_item_t make_item(input logic op);
    xform_item_t it;
    it.op = op;
    for (int k = 0; k < 3; k++) begin
      it.pos[k] = pick_value(64 * UNIT);
      it.ang[k] = 16'($urandom);
      it.scl[k] = pick_value(4 * UNIT);
    end
    return it;
  endfunction

  function automatic xform_item_t fill_item(input logic op, input logic [31:0] p,
                                            input logic [15:0] a, input logic [31:0] s);
    xform_item_t it;
    it.op = op;
    for (int k = 0; k < 3; k++) begin
      it.pos[k] = p;
      it.ang[k] = a;
      it.scl[k] = s;
    end
    return it;
  endfunction

  task automatic test_directed();
    xform_item_t it;
    // children of the identity parent left by reset
    send_item(fill_item(OP_CHILD, 32'h0001_8000, 16'h1234, UNIT));
    send_item(fill_item(OP_CHILD, 32'h7FFF_FFFF, 16'hFFFF, 32'h7FFF_FFFF));
    send_item(fill_item(OP_CHILD, 32'h8000_0000, 16'h0000, 32'h8000_0000));
    // quarter turns and the zero angle are exact
    send_item(fill_item(OP_LOAD, 32'h0010_0000, 16'h4000, UNIT));
    send_item(fill_item(OP_CHILD, 32'h0002_0000, 16'h0001, UNIT));
    send_item(fill_item(OP_LOAD, 32'hFFF0_0000, 16'h8000, 32'h0002_0000));
    send_item(fill_item(OP_CHILD, 32'h0003_4000, 16'h8000, 32'hFFFF_0000));
    send_item(fill_item(OP_LOAD, 32'h0, 16'hC000, UNIT));
    send_item(fill_item(OP_CHILD, 32'h0001_0000, 16'h4000, UNIT));
    // saturating scale and position sums
    send_item(fill_item(OP_LOAD, 32'h7FFF_FFFF, 16'h0000, 32'h7FFF_FFFF));
    send_item(fill_item(OP_CHILD, 32'h7FFF_FFFF, 16'hFFFF, 32'h7FFF_FFFF));
    send_item(fill_item(OP_CHILD, 32'h8000_0000, 16'h0001, 32'h8000_0000));
    send_item(fill_item(OP_LOAD, 32'h8000_0000, 16'hFFFF, 32'h8000_0000));
    send_item(fill_item(OP_CHILD, 32'h7FFF_FFFF, 16'h0001, 32'h7FFF_FFFF));
    send_item(fill_item(OP_CHILD, 32'h0000_0000, 16'h8000, 32'h0000_0000));
    // mixed angles per axis
    it = fill_item(OP_LOAD, 32'h0000_8000, 16'h2000, UNIT);
    it.ang[1] = 16'h6000;
    it.ang[2] = 16'hE555;
    send_item(it);
    send_item(fill_item(OP_CHILD, 32'h0005_0000, 16'h7FFF, 32'h0001_8000));
    send_item(fill_item(OP_CHILD, 32'hFFFB_0000, 16'h8001, 32'hFFFE_8000));
    // back to the root
    send_item(fill_item(OP_LOAD, 32'h0, 16'h0000, UNIT));
    send_item(fill_item(OP_CHILD, 32'hDEAD_BEEF, 16'hA5A5, 32'h0000_FFFF));
  endtask

  // Parent load followed by a few children; an odd stray child as noise.
  task automatic test_random(input int items, input int tx_pct, input int rx_pct);
    int sent;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) != 0) begin
        send_item(make_item(OP_LOAD));
        sent++;
      end
      repeat ($urandom_range(1, 5)) begin
        send_item(make_item(OP_CHILD));
        sent++;
      end
    end
  endtask

  // Hold the result side off while items keep coming.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = ~hold_req;
    send_item(make_item(OP_LOAD));
    repeat (8) send_item(make_item(OP_CHILD));
  endtask

  always @(posedge clk) begin
    composed_t r;
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        errors++;
      end else begin
        r = expected_q.pop_front();
        if (out_global_x !== r.gpos[0]) report_mismatch("global_x", out_global_x, r.gpos[0]);
        if (out_global_y !== r.gpos[1]) report_mismatch("global_y", out_global_y, r.gpos[1]);
        if (out_global_z !== r.gpos[2]) report_mismatch("global_z", out_global_z, r.gpos[2]);
        if (out_global_angle_x !== r.gang[0])
          report_mismatch("global_angle_x", out_global_angle_x, r.gang[0]);
        if (out_global_angle_y !== r.gang[1])
          report_mismatch("global_angle_y", out_global_angle_y, r.gang[1]);
        if (out_global_angle_z !== r.gang[2])
          report_mismatch("global_angle_z", out_global_angle_z, r.gang[2]);
        if (out_global_scale_x !== r.gscl[0])
          report_mismatch("global_scale_x", out_global_scale_x, r.gscl[0]);
        if (out_global_scale_y !== r.gscl[1])
          report_mismatch("global_scale_y", out_global_scale_y, r.gscl[1]);
        if (out_global_scale_z !== r.gscl[2])
          report_mismatch("global_scale_z", out_global_scale_z, r.gscl[2]);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("transform_compose_3d_euler_top_tb: FAIL");
    $finish;
  end

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_op      <= OP_LOAD;
    in_pos_x   <= '0;
    in_pos_y   <= '0;
    in_pos_z   <= '0;
    in_angle_x <= '0;
    in_angle_y <= '0;
    in_angle_z <= '0;
    in_scale_x <= '0;
    in_scale_y <= '0;
    in_scale_z <= '0;
    reset_parent();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(210, 27, 53);
    test_random(210, 53, 27);
    test_backpressure();
    test_random(210, 0, 0);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("transform_compose_3d_euler_top_tb: PASS");
    end else begin
      $display("transform_compose_3d_euler_top_tb: FAIL");
    end
    $finish;
  end

endmodule
